// ===== rtl/v3n_pkg.sv =====
package v3n_pkg;

    localparam int unsigned CompWidth = 16;
    localparam int unsigned SumWidth = 32;
    localparam int unsigned LenWidth = 16;
    localparam int unsigned FracBits = 14;
    localparam int unsigned QuoWidth = FracBits + 2;
    localparam int unsigned DivWidth = CompWidth + FracBits;
    localparam logic [QuoWidth-1:0] Q14One = QuoWidth'(16384);
    localparam logic [LenWidth-1:0] Q8One = LenWidth'(256);
    localparam int unsigned SqrtStepsPerStage = 2;
    localparam int unsigned DivStepsPerStage = 2;

    typedef struct packed {
        logic [CompWidth-1:0] mag;
        logic                 neg;
    } comp_t;

    typedef struct packed {
        comp_t [2:0] comp;
        logic        was_zero;
    } side_t;

endpackage

// ===== rtl/v3n_sqrt_pipe.sv =====
// Pipelined bit-by-bit square root, two result bits per stage.
module v3n_sqrt_pipe (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 advance,
    input  logic                                 in_valid,
    input  logic [v3n_pkg::SumWidth-1:0]         in_sum,
    input  v3n_pkg::side_t                       in_side,
    output logic                                 out_valid,
    output logic [v3n_pkg::LenWidth-1:0]         out_len,
    output v3n_pkg::side_t                       out_side
);
    localparam int unsigned Steps = v3n_pkg::LenWidth;
    localparam int unsigned Stages = Steps / v3n_pkg::SqrtStepsPerStage;
    localparam int unsigned RemW = v3n_pkg::LenWidth + 2;

    logic [Stages:1]                         valid_reg;
    logic [v3n_pkg::SumWidth-1:0]            rad_reg  [1:Stages];
    logic [RemW-1:0]                         rem_reg  [1:Stages];
    logic [v3n_pkg::LenWidth-1:0]            root_reg [1:Stages];
    v3n_pkg::side_t                          side_reg [1:Stages];

    for (genvar s = 0; s < Stages; s++) begin : g_stage
        logic                         valid_cur;
        logic [v3n_pkg::SumWidth-1:0] rad_cur;
        logic [RemW-1:0]              rem_cur;
        logic [v3n_pkg::LenWidth-1:0] root_cur;
        v3n_pkg::side_t               side_cur;
        logic [v3n_pkg::SumWidth-1:0] rad_next;
        logic [RemW-1:0]              rem_next;
        logic [v3n_pkg::LenWidth-1:0] root_next;

        if (s == 0) begin : g_first
            assign valid_cur = in_valid;
            assign rad_cur   = in_sum;
            assign rem_cur   = '0;
            assign root_cur  = '0;
            assign side_cur  = in_side;
        end else begin : g_later
            assign valid_cur = valid_reg[s];
            assign rad_cur   = rad_reg[s];
            assign rem_cur   = rem_reg[s];
            assign root_cur  = root_reg[s];
            assign side_cur  = side_reg[s];
        end

        always_comb begin
            logic [RemW-1:0] trial;
            rad_next  = rad_cur;
            rem_next  = rem_cur;
            root_next = root_cur;
            for (int k = 0; k < v3n_pkg::SqrtStepsPerStage; k++) begin
                rem_next  = {rem_next[RemW-3:0], rad_next[v3n_pkg::SumWidth-1 -: 2]};
                rad_next  = {rad_next[v3n_pkg::SumWidth-3:0], 2'b00};
                trial     = {root_next, 2'b01};
                if (rem_next >= trial) begin
                    rem_next  = rem_next - trial;
                    root_next = {root_next[v3n_pkg::LenWidth-2:0], 1'b1};
                end else begin
                    root_next = {root_next[v3n_pkg::LenWidth-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[s+1] <= 1'b0;
            end else if (advance) begin
                valid_reg[s+1] <= valid_cur;
            end
            if (advance) begin
                rad_reg[s+1]  <= rad_next;
                rem_reg[s+1]  <= rem_next;
                root_reg[s+1] <= root_next;
                side_reg[s+1] <= side_cur;
            end
        end
    end

    assign out_valid = valid_reg[Stages];
    assign out_len   = root_reg[Stages];
    assign out_side  = side_reg[Stages];
endmodule

// ===== rtl/v3n_div_pipe.sv =====
// Three parallel restoring dividers, pipelined, two quotient bits per stage.
module v3n_div_pipe (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 advance,
    input  logic                                 in_valid,
    input  logic [v3n_pkg::LenWidth-1:0]         in_len,
    input  v3n_pkg::side_t                       in_side,
    output logic                                 out_valid,
    output logic [v3n_pkg::LenWidth-1:0]         out_len,
    output logic [v3n_pkg::QuoWidth-1:0]         out_quo [3],
    output v3n_pkg::side_t                       out_side
);
    // Quotient never exceeds 2^15 since |c| <= len; 16 bits of quotient suffice.
    localparam int unsigned Steps = v3n_pkg::QuoWidth;
    localparam int unsigned Stages = Steps / v3n_pkg::DivStepsPerStage;
    localparam int unsigned RemW = v3n_pkg::LenWidth + 1;
    localparam int unsigned NumW = v3n_pkg::QuoWidth;

    logic [Stages:1]                 valid_reg;
    logic [v3n_pkg::LenWidth-1:0]    len_reg  [1:Stages];
    v3n_pkg::side_t                  side_reg [1:Stages];
    logic [RemW-1:0]                 rem_reg  [1:Stages][3];
    logic [NumW-1:0]                 num_reg  [1:Stages][3];

    for (genvar s = 0; s < Stages; s++) begin : g_stage
        logic                         valid_cur;
        logic [v3n_pkg::LenWidth-1:0] len_cur;
        v3n_pkg::side_t               side_cur;
        logic [RemW-1:0]              rem_cur [3];
        logic [NumW-1:0]              num_cur [3];
        logic [RemW-1:0]              rem_next [3];
        logic [NumW-1:0]              num_next [3];

        if (s == 0) begin : g_first
            assign valid_cur = in_valid;
            assign len_cur   = in_len;
            assign side_cur  = in_side;
            always_comb begin
                for (int c = 0; c < 3; c++) begin
                    // Dividend is mag * 2^14: the upper part preloads the remainder.
                    rem_cur[c] = RemW'(in_side.comp[c].mag >> (NumW - v3n_pkg::FracBits));
                    num_cur[c] = NumW'({in_side.comp[c].mag, {v3n_pkg::FracBits{1'b0}}});
                end
            end
        end else begin : g_later
            assign valid_cur = valid_reg[s];
            assign len_cur   = len_reg[s];
            assign side_cur  = side_reg[s];
            always_comb begin
                for (int c = 0; c < 3; c++) begin
                    rem_cur[c] = rem_reg[s][c];
                    num_cur[c] = num_reg[s][c];
                end
            end
        end

        always_comb begin
            logic [RemW-1:0] shifted;
            for (int c = 0; c < 3; c++) begin
                rem_next[c] = rem_cur[c];
                num_next[c] = num_cur[c];
                for (int k = 0; k < v3n_pkg::DivStepsPerStage; k++) begin
                    shifted = {rem_next[c][RemW-2:0], num_next[c][NumW-1]};
                    if (shifted >= {1'b0, len_cur}) begin
                        rem_next[c] = shifted - {1'b0, len_cur};
                        num_next[c] = {num_next[c][NumW-2:0], 1'b1};
                    end else begin
                        rem_next[c] = shifted;
                        num_next[c] = {num_next[c][NumW-2:0], 1'b0};
                    end
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[s+1] <= 1'b0;
            end else if (advance) begin
                valid_reg[s+1] <= valid_cur;
            end
            if (advance) begin
                len_reg[s+1]  <= len_cur;
                side_reg[s+1] <= side_cur;
                for (int c = 0; c < 3; c++) begin
                    rem_reg[s+1][c] <= rem_next[c];
                    num_reg[s+1][c] <= num_next[c];
                end
            end
        end
    end

    assign out_valid = valid_reg[Stages];
    assign out_len   = len_reg[Stages];
    assign out_side  = side_reg[Stages];
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            out_quo[c] = num_reg[Stages][c];
        end
    end
endmodule

// ===== rtl/vector3_normalise_with_magnitude_unit.sv =====
// Normalizes one signed Q8.8 vector per cycle into signed Q1.14 unit components
// and an unsigned Q8.8 length (floor of the root), truncating toward zero. A zero
// vector yields x = 1.0, length 1.0 and was_zero set. Throughput is one transfer
// per cycle while not stalled. The squares and their sum are registered in turn,
// then follow the two-bit-per-stage square root, the three dividers, and one
// register for sign and output. The whole pipe halts while m_ready is low and
// the output register is full.
module vector3_normalise_with_magnitude_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [v3n_pkg::CompWidth-1:0] s_vec_x,
    input  logic signed [v3n_pkg::CompWidth-1:0] s_vec_y,
    input  logic signed [v3n_pkg::CompWidth-1:0] s_vec_z,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [v3n_pkg::CompWidth-1:0] m_unit_x,
    output logic signed [v3n_pkg::CompWidth-1:0] m_unit_y,
    output logic signed [v3n_pkg::CompWidth-1:0] m_unit_z,
    output logic        [v3n_pkg::LenWidth-1:0]  m_length,
    output logic                                m_was_zero
);
    logic advance;
    assign advance = !m_valid || m_ready;
    assign s_ready = advance;

    // Stage 1: magnitudes and squares.
    logic                              v1_reg;
    v3n_pkg::side_t                    side1_reg;
    logic [2*v3n_pkg::CompWidth-1:0]   sq_reg [3];
    v3n_pkg::side_t                    side1_next;

    always_comb begin
        logic signed [v3n_pkg::CompWidth-1:0] c_in [3];
        c_in[0] = s_vec_x;
        c_in[1] = s_vec_y;
        c_in[2] = s_vec_z;
        side1_next = '0;
        for (int c = 0; c < 3; c++) begin
            side1_next.comp[c].neg = c_in[c][v3n_pkg::CompWidth-1];
            side1_next.comp[c].mag = c_in[c][v3n_pkg::CompWidth-1]
                ? v3n_pkg::CompWidth'(-c_in[c]) : c_in[c];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (advance) begin
            v1_reg <= s_valid;
        end
        if (advance) begin
            side1_reg <= side1_next;
            for (int c = 0; c < 3; c++) begin
                sq_reg[c] <= side1_next.comp[c].mag * side1_next.comp[c].mag;
            end
        end
    end

    // Stage 2: sum of squares and zero detect.
    logic                          v2_reg;
    v3n_pkg::side_t                side2_reg;
    logic [v3n_pkg::SumWidth-1:0]  sum_reg;
    logic [v3n_pkg::SumWidth-1:0]  sum_next;
    v3n_pkg::side_t                side2_next;

    assign sum_next = sq_reg[0] + sq_reg[1] + sq_reg[2];

    always_comb begin
        side2_next          = side1_reg;
        side2_next.was_zero = (sum_next == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (advance) begin
            v2_reg <= v1_reg;
        end
        if (advance) begin
            sum_reg   <= sum_next;
            side2_reg <= side2_next;
        end
    end

    logic                          v3_valid;
    logic [v3n_pkg::LenWidth-1:0]  sq_len;
    v3n_pkg::side_t                side3;

    v3n_sqrt_pipe u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .in_valid  (v2_reg),
        .in_sum    (sum_reg),
        .in_side   (side2_reg),
        .out_valid (v3_valid),
        .out_len   (sq_len),
        .out_side  (side3)
    );

    logic                          v4_valid;
    logic [v3n_pkg::LenWidth-1:0]  len4;
    logic [v3n_pkg::QuoWidth-1:0]  quo4 [3];
    v3n_pkg::side_t                side4;
    logic [v3n_pkg::LenWidth-1:0]  div_len;

    // A zero length would divide by zero; those results are replaced below.
    assign div_len = side3.was_zero ? v3n_pkg::Q8One : sq_len;

    v3n_div_pipe u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .in_valid  (v3_valid),
        .in_len    (div_len),
        .in_side   (side3),
        .out_valid (v4_valid),
        .out_len   (len4),
        .out_quo   (quo4),
        .out_side  (side4)
    );

    // Output register: clamp, restore sign, apply zero default.
    logic                                  m_valid_reg;
    logic [v3n_pkg::CompWidth-1:0]         unit_reg [3];
    logic [v3n_pkg::LenWidth-1:0]          len_reg;
    logic                                  zero_reg;
    logic [v3n_pkg::CompWidth-1:0]         unit_next [3];

    always_comb begin
        logic [v3n_pkg::QuoWidth-1:0] q;
        for (int c = 0; c < 3; c++) begin
            q = (quo4[c] > v3n_pkg::Q14One) ? v3n_pkg::Q14One : quo4[c];
            unit_next[c] = side4.comp[c].neg ? v3n_pkg::CompWidth'(-q)
                                             : v3n_pkg::CompWidth'(q);
        end
        if (side4.was_zero) begin
            unit_next[0] = v3n_pkg::CompWidth'(v3n_pkg::Q14One);
            unit_next[1] = '0;
            unit_next[2] = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= v4_valid;
        end
        if (advance) begin
            for (int c = 0; c < 3; c++) begin
                unit_reg[c] <= unit_next[c];
            end
            len_reg  <= side4.was_zero ? v3n_pkg::Q8One : len4;
            zero_reg <= side4.was_zero;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_unit_x   = unit_reg[0];
    assign m_unit_y   = unit_reg[1];
    assign m_unit_z   = unit_reg[2];
    assign m_length   = len_reg;
    assign m_was_zero = zero_reg;

    a_zero_default: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_was_zero |-> m_length == v3n_pkg::Q8One)
        else $error("zero vector without default length");
    a_unit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ($signed(m_unit_x) <= 16384 && $signed(m_unit_x) >= -16384))
        else $error("unit x out of range");
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(v4_valid) && $stable(m_length))
        else $error("pipeline moved during stall");
endmodule

// ===== tb/v3n_checker.sv =====
module v3n_checker (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    input  logic                                 s_ready,
    input  logic signed [v3n_pkg::CompWidth-1:0] s_vec_x,
    input  logic signed [v3n_pkg::CompWidth-1:0] s_vec_y,
    input  logic signed [v3n_pkg::CompWidth-1:0] s_vec_z,
    input  logic                                 m_valid,
    input  logic                                 m_ready,
    input  logic signed [v3n_pkg::CompWidth-1:0] m_unit_x,
    input  logic signed [v3n_pkg::CompWidth-1:0] m_unit_y,
    input  logic signed [v3n_pkg::CompWidth-1:0] m_unit_z,
    input  logic        [v3n_pkg::LenWidth-1:0]  m_length,
    input  logic                                 m_was_zero,
    output int                                   fail_count,
    output int                                   pending,
    output int                                   zero_seen
);

    typedef struct packed {
        logic [15:0] ux;
        logic [15:0] uy;
        logic [15:0] uz;
        logic [15:0] len;
        logic        zero;
    } norm_t;

    norm_t norm_q[$];

    function automatic logic [31:0] floor_root(input logic [31:0] v);
        logic [31:0] r;
        r = 0;
        for (int b = 15; b >= 0; b--) begin
            if (64'(r | (32'd1 << b)) * 64'(r | (32'd1 << b)) <= 64'(v))
                r = r | (32'd1 << b);
        end
        return r;
    endfunction

    function automatic logic [15:0] unit_comp(input logic signed [15:0] c,
                                              input logic [31:0] len);
        logic [31:0] mag;
        logic [31:0] q;
        mag = (c < 0) ? 32'(-int'(c)) : 32'(int'(c));
        q = (mag * 32'd16384) / len;
        if (q > 32'd16384) q = 32'd16384;
        return (c < 0) ? 16'(32'h10000 - q) : q[15:0];
    endfunction

    function automatic norm_t normalize(input logic signed [15:0] x,
                                        input logic signed [15:0] y,
                                        input logic signed [15:0] z);
        norm_t r;
        logic [31:0] sum;
        logic [31:0] len;
        sum = 32'(int'(x) * int'(x)) + 32'(int'(y) * int'(y)) + 32'(int'(z) * int'(z));
        if (sum == 0) begin
            r = '{16'd16384, 16'd0, 16'd0, 16'd256, 1'b1};
        end else begin
            len = floor_root(sum);
            r = '{unit_comp(x, len), unit_comp(y, len), unit_comp(z, len),
                  len[15:0], 1'b0};
        end
        return r;
    endfunction

    task automatic report(input string what, input logic [15:0] got, input logic [15:0] exp);
        $display("error: %s got %0d expected %0d", what, got, exp);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        norm_t e;
        if (!aresetn) begin
            fail_count = 0;
            zero_seen = 0;
            norm_q.delete();
            pending <= 0;
        end else begin
            if (s_valid && s_ready)
                norm_q.push_back(normalize(s_vec_x, s_vec_y, s_vec_z));
            if (m_valid && m_ready) begin
                if (norm_q.size() == 0) begin
                    report("unexpected transfer", m_length, 16'd0);
                end else begin
                    e = norm_q.pop_front();
                    if (m_unit_x !== e.ux) report("unit_x", m_unit_x, e.ux);
                    if (m_unit_y !== e.uy) report("unit_y", m_unit_y, e.uy);
                    if (m_unit_z !== e.uz) report("unit_z", m_unit_z, e.uz);
                    if (m_length !== e.len) report("length", m_length, e.len);
                    if (m_was_zero !== e.zero)
                        report("was_zero", 16'(m_was_zero), 16'(e.zero));
                    if (e.zero) zero_seen++;
                end
            end
            pending <= norm_q.size();
        end
    end

endmodule

// ===== tb/tb_vector3_normalise_with_magnitude_unit.sv =====
module tb_vector3_normalise_with_magnitude_unit;

    logic aclk = 0;
    logic aresetn = 0;
    logic s_valid = 0;
    logic s_ready;
    logic signed [15:0] s_vec_x = 0;
    logic signed [15:0] s_vec_y = 0;
    logic signed [15:0] s_vec_z = 0;
    logic m_valid;
    logic m_ready = 0;
    logic signed [15:0] m_unit_x;
    logic signed [15:0] m_unit_y;
    logic signed [15:0] m_unit_z;
    logic [15:0] m_length;
    logic m_was_zero;
    int fail_count;
    int pending;
    int zero_seen;
    int cycles = 0;
    int sent = 0;

    always #1 aclk = ~aclk;

    vector3_normalise_with_magnitude_unit DUT (.*);

    v3n_checker checker_i (.*);

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("vector3_normalise_with_magnitude_unit: mismatch");
            $finish;
        end
    end

    // The receiver holds m_ready low for a random gap before most transfers and
    // takes others at once. Handshake levels are checked at the falling edge,
    // where they are settled for the next rising edge.
    initial begin
        int gap;
        repeat (9) @(posedge aclk);
        forever begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
            if (gap > 0) begin
                m_ready <= 0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1;
            @(negedge aclk);
            while (!m_valid) @(negedge aclk);
            @(posedge aclk);
        end
    end

    task automatic send(input logic [15:0] x, input logic [15:0] y, input logic [15:0] z);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            s_valid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1;
        s_vec_x <= x;
        s_vec_y <= y;
        s_vec_z <= z;
        @(negedge aclk);
        while (!s_ready) @(negedge aclk);
        @(posedge aclk);
        sent++;
    endtask

    function automatic logic [15:0] rnd_comp();
        case ($urandom_range(0, 4))
            0: return 16'($urandom_range(0, 7)) - 16'd3;
            1: return $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        send(16'd0, 16'd0, 16'd0);
        send(16'h8000, 16'h8000, 16'h8000);
        send(16'h7fff, 16'h7fff, 16'h7fff);
        send(16'h7fff, 16'd0, 16'd0);
        send(16'h8000, 16'd0, 16'd0);
        send(16'd0, 16'h8000, 16'd0);
        send(16'd0, 16'd0, 16'h7fff);
        send(16'd1, 16'd0, 16'd0);
        send(16'hffff, 16'd0, 16'd0);
        send(16'd0, 16'd1, 16'd0);
        send(16'd0, 16'd0, 16'hffff);
        send(16'd1, 16'd1, 16'd1);
        send(16'hffff, 16'hffff, 16'hffff);
        send(16'd256, 16'd256, 16'd256);
        send(16'd3, 16'd4, 16'd0);
        send(16'hfffd, 16'd0, 16'hfffc);
        send(16'h5555, 16'haaaa, 16'h0f0f);
        send(16'd0, 16'd0, 16'd0);
        for (int i = 0; i < 450; i++) begin
            if ($urandom_range(0, 40) == 0)
                send(16'd0, 16'd0, 16'd0);
            else
                send(rnd_comp(), rnd_comp(), rnd_comp());
        end
        s_valid <= 0;
        while (pending != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        $display("Sent %0d vectors, including %0d zero vectors, with random stalls on both sides.",
                 sent, zero_seen);
        if (fail_count == 0) begin
            $display("vector3_normalise_with_magnitude_unit: match");
        end else begin
            $display("vector3_normalise_with_magnitude_unit: mismatch");
        end
        $finish;
    end

endmodule
